### rtl/pfa_pkg.sv
`default_nettype none
package pfa_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_FILL,
    S_TICK
  } state_t;

  localparam logic [1:0] OP_MAP  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [2:0] ST_MAPPED   = 3'd0;
  localparam logic [2:0] ST_HINT     = 3'd1;
  localparam logic [2:0] ST_FREE     = 3'd2;
  localparam logic [2:0] ST_REPLACED = 3'd3;
  localparam logic [2:0] ST_NO_FRAME = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  localparam int AGE_W = 16;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam logic [AGE_W-1:0] AGE_NEW = 16'd1;
  localparam int WORD_W = 32;
  localparam int WORDS = 4;

  typedef struct packed {
    logic free_hit;
    logic victim_hit;
    logic scan_done;
  } scan_flags_t;

endpackage
`default_nettype wire

### rtl/pfa_victim_scan.sv
`default_nettype none
module pfa_victim_scan #(
  parameter int FW = 6,
  parameter int PW = 4,
  parameter int GW = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         clear,
  input  wire logic                         sample,
  input  wire logic                         last,
  input  wire logic [FW-1:0]                index,
  input  wire logic                         free,
  input  wire logic [PW-1:0]                owner_proc,
  input  wire logic [GW-1:0]                owner_page,
  input  wire logic [pfa_pkg::AGE_W-1:0]    age,
  input  wire logic [PW-1:0]                req_proc,
  output pfa_pkg::scan_flags_t              flags,
  output logic [FW-1:0]                     free_index,
  output logic [FW-1:0]                     victim_index,
  output logic [PW-1:0]                     victim_proc,
  output logic [GW-1:0]                     victim_page
);

  logic [pfa_pkg::AGE_W-1:0] best_age;
  logic                      older;

  // strict compare keeps the lowest index among equal ages
  assign older = sample && !free && (owner_proc != req_proc) && (age > best_age);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      flags <= '0;
    end else if (sample) begin
      if (free && !flags.free_hit) begin
        flags.free_hit <= 1'b1;
      end
      if (older) begin
        flags.victim_hit <= 1'b1;
      end
      if (last) begin
        flags.scan_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      best_age <= '0;
    end else begin
      if (sample && free && !flags.free_hit) begin
        free_index <= index;
      end
      if (older) begin
        best_age     <= age;
        victim_index <= index;
        victim_proc  <= owner_proc;
        victim_page  <= owner_page;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/page_frame_allocator_age_replace.sv
`default_nettype none
// channel  | ports                                             | handshake
// ---------+---------------------------------------------------+---------------------------
// request  | opcode process_id page_number frame_select        | start, taken when !busy
//          | data_word0..3                                     |
// result   | status frame_used evicted_process evicted_page    | done, one cycle, no stall
//          | frame_occupied read_word0..3 frame_age            |
//
// read and unused opcode: result decided in S_LOOK and shown through the registered result fields
// age tick: one age memory read-modify-write per owned frame, saturating at the maximum age
// map: when unmapped and frame_select is not free, a frame scan through the owner and age memories
// reset clears the control state and valid bits, not the memories, so the block takes requests right after reset
// busy stays high from the taken transaction until the cycle its result is shown
module page_frame_allocator_age_replace #(
  parameter int FRAMES            = 64,
  parameter int PROCESSES         = 16,
  parameter int PAGES_PER_PROCESS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [1:0]         opcode,
  input  wire logic [3:0]         process_id,
  input  wire logic [3:0]         page_number,
  input  wire logic [5:0]         frame_select,
  input  wire logic signed [31:0] data_word0,
  input  wire logic signed [31:0] data_word1,
  input  wire logic signed [31:0] data_word2,
  input  wire logic signed [31:0] data_word3,
  output logic                    busy,
  output logic                    done,
  output logic [2:0]              status,
  output logic [5:0]              frame_used,
  output logic [3:0]              evicted_process,
  output logic [3:0]              evicted_page,
  output logic                    frame_occupied,
  output logic signed [31:0]      read_word0,
  output logic signed [31:0]      read_word1,
  output logic signed [31:0]      read_word2,
  output logic signed [31:0]      read_word3,
  output logic [15:0]             frame_age
);

  localparam int FW      = $clog2(FRAMES);
  localparam int PW      = $clog2(PROCESSES);
  localparam int GW      = $clog2(PAGES_PER_PROCESS);
  localparam int ENTRIES = PROCESSES * PAGES_PER_PROCESS;
  localparam int IW      = $clog2(ENTRIES);
  localparam int CW      = $clog2(FRAMES + 1);
  localparam int DW      = pfa_pkg::WORDS * pfa_pkg::WORD_W;
  localparam int AW      = pfa_pkg::AGE_W;

  pfa_pkg::state_t state, state_next;

  logic [1:0]    op_r;
  logic [3:0]    pid_r;
  logic [3:0]    page_r;
  logic [5:0]    fsel_r;
  logic [DW-1:0] words_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] idx_in;

  logic [CW-1:0] cnt;
  logic          cnt_live;
  logic          chk_vld;
  logic          chk_last;
  logic [FW-1:0] chk_addr;

  logic [FW-1:0] fill_f;
  logic [2:0]    fill_status;
  logic          evict_r;

  logic [ENTRIES-1:0] map_valid;
  logic [FW-1:0]      map_mem [ENTRIES];
  logic [FW-1:0]      map_rd;

  logic [FRAMES-1:0]  own_valid;
  logic [PW+GW-1:0]   own_mem [FRAMES];
  logic [PW+GW-1:0]   own_rd;

  logic [AW-1:0]      age_mem [FRAMES];
  logic [AW-1:0]      age_rd;
  logic [FW-1:0]      age_raddr;
  logic               age_we;
  logic [FW-1:0]      age_waddr;
  logic [AW-1:0]      age_wdata;
  logic [AW-1:0]      age_eff;

  logic [DW-1:0]      data_mem [FRAMES];
  logic [DW-1:0]      data_rd;

  logic                 accept;
  logic                 pid_ok;
  logic                 map_hit;
  logic [FW-1:0]        hint_f;
  logic                 hint_in;
  logic                 hint_occ;
  logic                 hint_free;
  logic                 scan_sample;
  logic [IW-1:0]        victim_idx;

  pfa_pkg::scan_flags_t flags;
  logic [FW-1:0]        free_index;
  logic [FW-1:0]        victim_index;
  logic [PW-1:0]        victim_proc;
  logic [GW-1:0]        victim_page;

  logic          done_next;
  logic [2:0]    status_next;
  logic [5:0]    frame_used_next;
  logic [3:0]    evicted_process_next;
  logic [3:0]    evicted_page_next;
  logic          frame_occupied_next;
  logic [DW-1:0] read_words_next;
  logic [AW-1:0] frame_age_next;

  assign busy   = (state != pfa_pkg::S_IDLE);
  assign accept = start && !busy;

  assign idx_in = IW'(32'(process_id) * PAGES_PER_PROCESS + 32'(page_number));

  assign pid_ok    = (32'(pid_r) < PROCESSES) && (32'(page_r) < PAGES_PER_PROCESS);
  assign map_hit   = map_valid[idx_r];
  assign hint_f    = FW'(fsel_r);
  assign hint_in   = (32'(fsel_r) < FRAMES);
  assign hint_occ  = hint_in && own_valid[hint_f];
  assign hint_free = hint_in && !own_valid[hint_f];

  assign cnt_live   = (cnt < CW'(FRAMES));
  assign age_eff    = own_valid[chk_addr] ? age_rd : '0;
  assign scan_sample = chk_vld && (state == pfa_pkg::S_SCAN);
  assign victim_idx = IW'(32'(victim_proc) * PAGES_PER_PROCESS + 32'(victim_page));

  pfa_victim_scan #(
    .FW (FW),
    .PW (PW),
    .GW (GW)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .clear        (state == pfa_pkg::S_LOOK),
    .sample       (scan_sample),
    .last         (chk_last),
    .index        (chk_addr),
    .free         (!own_valid[chk_addr]),
    .owner_proc   (own_rd[PW+GW-1:GW]),
    .owner_page   (own_rd[GW-1:0]),
    .age          (age_eff),
    .req_proc     (PW'(pid_r)),
    .flags        (flags),
    .free_index   (free_index),
    .victim_index (victim_index),
    .victim_proc  (victim_proc),
    .victim_page  (victim_page)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pfa_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (opcode == pfa_pkg::OP_TICK) ? pfa_pkg::S_TICK : pfa_pkg::S_LOOK;
        end
      end
      pfa_pkg::S_LOOK: begin
        if (op_r == pfa_pkg::OP_MAP && pid_ok && !map_hit) begin
          state_next = hint_free ? pfa_pkg::S_FILL : pfa_pkg::S_SCAN;
        end else begin
          state_next = pfa_pkg::S_IDLE;
        end
      end
      pfa_pkg::S_SCAN: begin
        if (flags.free_hit) begin
          state_next = pfa_pkg::S_FILL;
        end else if (flags.scan_done) begin
          state_next = flags.victim_hit ? pfa_pkg::S_FILL : pfa_pkg::S_IDLE;
        end
      end
      pfa_pkg::S_FILL: begin
        state_next = pfa_pkg::S_IDLE;
      end
      pfa_pkg::S_TICK: begin
        if (chk_vld && chk_last) begin
          state_next = pfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pfa_pkg::S_IDLE;
      end
    endcase
  end

  // result fields
  always_comb begin
    done_next            = 1'b0;
    status_next          = pfa_pkg::ST_DONE;
    frame_used_next      = '0;
    evicted_process_next = '0;
    evicted_page_next    = '0;
    frame_occupied_next  = 1'b0;
    read_words_next      = '0;
    frame_age_next       = '0;
    case (state)
      pfa_pkg::S_LOOK: begin
        case (op_r)
          pfa_pkg::OP_MAP: begin
            if (!pid_ok) begin
              done_next   = 1'b1;
              status_next = pfa_pkg::ST_NO_FRAME;
            end else if (map_hit) begin
              done_next       = 1'b1;
              status_next     = pfa_pkg::ST_MAPPED;
              frame_used_next = 6'(map_rd);
            end
          end
          pfa_pkg::OP_READ: begin
            done_next       = 1'b1;
            frame_used_next = fsel_r;
            if (hint_occ) begin
              frame_occupied_next = 1'b1;
              read_words_next     = data_rd;
              frame_age_next      = age_rd;
            end
          end
          default: begin
            done_next = 1'b1;
          end
        endcase
      end
      pfa_pkg::S_SCAN: begin
        if (!flags.free_hit && flags.scan_done && !flags.victim_hit) begin
          done_next   = 1'b1;
          status_next = pfa_pkg::ST_NO_FRAME;
        end
      end
      pfa_pkg::S_FILL: begin
        done_next       = 1'b1;
        status_next     = fill_status;
        frame_used_next = 6'(fill_f);
        if (evict_r) begin
          evicted_process_next = 4'(victim_proc);
          evicted_page_next    = 4'(victim_page);
        end
      end
      pfa_pkg::S_TICK: begin
        done_next = chk_vld && chk_last;
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfa_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    status          <= status_next;
    frame_used      <= frame_used_next;
    evicted_process <= evicted_process_next;
    evicted_page    <= evicted_page_next;
    frame_occupied  <= frame_occupied_next;
    read_word0      <= read_words_next[31:0];
    read_word1      <= read_words_next[63:32];
    read_word2      <= read_words_next[95:64];
    read_word3      <= read_words_next[127:96];
    frame_age       <= frame_age_next;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= opcode;
      pid_r   <= process_id;
      page_r  <= page_number;
      fsel_r  <= frame_select;
      words_r <= {data_word3, data_word2, data_word1, data_word0};
      idx_r   <= idx_in;
    end
  end

  // frame sweep counter and the read pipeline behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      chk_vld <= 1'b0;
    end else begin
      if (state == pfa_pkg::S_SCAN || state == pfa_pkg::S_TICK) begin
        if (cnt_live) begin
          cnt <= cnt + CW'(1);
        end
      end else begin
        cnt <= '0;
      end
      chk_vld <= (state == pfa_pkg::S_SCAN || state == pfa_pkg::S_TICK) && cnt_live;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr <= cnt[FW-1:0];
    chk_last <= (cnt == CW'(FRAMES - 1));
  end

  // frame picked for the fill
  always_ff @(posedge clk) begin
    if (state == pfa_pkg::S_LOOK) begin
      fill_f      <= hint_f;
      fill_status <= pfa_pkg::ST_HINT;
      evict_r     <= 1'b0;
    end else if (state == pfa_pkg::S_SCAN) begin
      if (flags.free_hit) begin
        fill_f      <= free_index;
        fill_status <= pfa_pkg::ST_FREE;
        evict_r     <= 1'b0;
      end else begin
        fill_f      <= victim_index;
        fill_status <= pfa_pkg::ST_REPLACED;
        evict_r     <= 1'b1;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= '0;
      own_valid <= '0;
    end else if (state == pfa_pkg::S_FILL) begin
      if (evict_r) begin
        map_valid[victim_idx] <= 1'b0;
      end
      map_valid[idx_r]  <= 1'b1;
      own_valid[fill_f] <= 1'b1;
    end
  end

  // page table
  always_ff @(posedge clk) begin
    if (state == pfa_pkg::S_FILL) begin
      map_mem[idx_r] <= fill_f;
    end
    map_rd <= map_mem[idx_in];
  end

  // frame owner
  always_ff @(posedge clk) begin
    if (state == pfa_pkg::S_FILL) begin
      own_mem[fill_f] <= {PW'(pid_r), GW'(page_r)};
    end
    own_rd <= own_mem[cnt[FW-1:0]];
  end

  // frame contents
  always_ff @(posedge clk) begin
    if (state == pfa_pkg::S_FILL) begin
      data_mem[fill_f] <= words_r;
    end
    data_rd <= data_mem[FW'(frame_select)];
  end

  // frame ages: tick writes back one slot behind the read
  always_comb begin
    age_raddr = (state == pfa_pkg::S_IDLE) ? FW'(frame_select) : cnt[FW-1:0];
    age_we    = 1'b0;
    age_waddr = chk_addr;
    age_wdata = age_rd + AW'(1);
    if (state == pfa_pkg::S_FILL) begin
      age_we    = 1'b1;
      age_waddr = fill_f;
      age_wdata = pfa_pkg::AGE_NEW;
    end else if (state == pfa_pkg::S_TICK && chk_vld && own_valid[chk_addr] &&
                 age_rd != pfa_pkg::AGE_MAX) begin
      age_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
    age_rd <= age_mem[age_raddr];
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("taken transaction did not raise busy");

  a_fill_unmapped: assert property (@(posedge clk) disable iff (rst)
    (state == pfa_pkg::S_FILL) |-> !map_valid[idx_r])
    else $error("fill of a page that is already mapped");

  a_fill_free: assert property (@(posedge clk) disable iff (rst)
    (state == pfa_pkg::S_FILL && !evict_r) |-> !own_valid[fill_f])
    else $error("fill without eviction into an owned frame");

  a_victim_other: assert property (@(posedge clk) disable iff (rst)
    (state == pfa_pkg::S_FILL && evict_r) |-> (victim_proc != PW'(pid_r)))
    else $error("victim frame belongs to the requester");

endmodule
`default_nettype wire
